// ===== hdl/stx_dfr_pkg.sv =====
// ----------------------------------------------------------------------------
// stx_dfr_pkg
// shared types and constants of the stx length-prefixed frame deframer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stx_dfr_pkg;

    // frame buffer size that bounds the accepted payload length
    localparam int BUFFER_DEPTH = 128;

    localparam int POS_W = 8;
    localparam int IDX_W = POS_W + 1;

    localparam logic [7:0]       START_BYTE     = 8'h02;
    localparam logic [IDX_W-1:0] PAYLOAD_OFFSET = IDX_W'(3);
    // first index of the second trailer byte is length + overhead - 1
    localparam logic [IDX_W-1:0] TRAILER_END    = IDX_W'(4);
    localparam logic [IDX_W-1:0] MAX_LEN        = IDX_W'(BUFFER_DEPTH - 5);
    localparam logic [IDX_W-1:0] DISCARD_END    = IDX_W'(BUFFER_DEPTH - 1);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN,
        PH_BODY,
        PH_DISCARD
    } phase_t;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    typedef struct packed {
        logic       valid;
        logic       kind;
        logic [7:0] data;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/stx_dfr_parser.sv =====
// ----------------------------------------------------------------------------
// stx_dfr_parser
// frame phase and position tracking, one word per step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stx_dfr_parser
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire logic [7:0]            rx_word,
    output stx_dfr_pkg::result_t       res
);

    stx_dfr_pkg::phase_t                    phase_reg, phase_next;
    logic [stx_dfr_pkg::POS_W-1:0]          pos_reg, pos_next;
    logic [7:0]                             len_reg, len_next;
    logic [stx_dfr_pkg::IDX_W-1:0]          idx;
    logic [stx_dfr_pkg::IDX_W-1:0]          len_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= stx_dfr_pkg::PH_HUNT;
            pos_reg   <= '0;
            len_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
        end
    end

    always_comb
    begin
        idx        = {1'b0, pos_reg} + stx_dfr_pkg::IDX_W'(1);
        len_ext    = {1'b0, len_reg};
        phase_next = phase_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        res        = '0;
        unique case (phase_reg)
            stx_dfr_pkg::PH_LEN:
            begin
                pos_next = idx[stx_dfr_pkg::POS_W-1:0];
                len_next = rx_word;
                if ({1'b0, rx_word} > stx_dfr_pkg::MAX_LEN)
                begin
                    phase_next = stx_dfr_pkg::PH_DISCARD;
                end
                else
                begin
                    phase_next = stx_dfr_pkg::PH_BODY;
                end
            end
            stx_dfr_pkg::PH_BODY:
            begin
                pos_next = idx[stx_dfr_pkg::POS_W-1:0];
                // payload window, then trailer, then end marker
                if (idx >= stx_dfr_pkg::PAYLOAD_OFFSET &&
                    idx < len_ext + stx_dfr_pkg::PAYLOAD_OFFSET)
                begin
                    res.valid = 1'b1;
                    res.kind  = stx_dfr_pkg::KIND_PAYLOAD;
                    res.data  = rx_word;
                end
                else if (idx >= len_ext + stx_dfr_pkg::TRAILER_END)
                begin
                    phase_next = stx_dfr_pkg::PH_HUNT;
                    pos_next   = '0;
                    res.valid  = 1'b1;
                    res.kind   = stx_dfr_pkg::KIND_END;
                end
            end
            stx_dfr_pkg::PH_DISCARD:
            begin
                pos_next = idx[stx_dfr_pkg::POS_W-1:0];
                if (idx >= stx_dfr_pkg::DISCARD_END)
                begin
                    phase_next = stx_dfr_pkg::PH_HUNT;
                    pos_next   = '0;
                end
            end
            stx_dfr_pkg::PH_HUNT:
            begin
                pos_next = '0;
                if (rx_word == stx_dfr_pkg::START_BYTE)
                begin
                    phase_next = stx_dfr_pkg::PH_LEN;
                end
            end
            default:
            begin
                phase_next = stx_dfr_pkg::PH_HUNT;
                pos_next   = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/stx_dfr_outreg.sv =====
// ----------------------------------------------------------------------------
// stx_dfr_outreg
// result register facing the downstream valid/ready channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stx_dfr_outreg
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load,
    input  wire stx_dfr_pkg::result_t  res,
    output logic                       slot_free,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output logic                       kind,
    output logic [7:0]                 data
);

    logic       valid_reg, valid_next;
    logic       kind_reg;
    logic [7:0] data_reg;

    always_comb
    begin
        slot_free  = !valid_reg || res_ready;
        valid_next = valid_reg;
        if (load && res.valid)
        begin
            valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res.valid)
        begin
            kind_reg <= res.kind;
            data_reg <= res.data;
        end
    end

    assign res_valid = valid_reg;
    assign kind      = kind_reg;
    assign data      = data_reg;

endmodule

`default_nettype wire

// ===== hdl/stx_length_frame_deframer_core.sv =====
// ----------------------------------------------------------------------------
// stx_length_frame_deframer_core
// stx length-prefixed frame deframer, unless the result channel stalls it, one received word per cycle
// ----------------------------------------------------------------------------
// usage
//   rx channel  : rx_valid / rx_ready / rx_byte, one received word per handshake
//   res channel : res_valid / res_ready / kind / data, one result word per
//                 handshake; kind 0 carries a payload byte in data, kind 1 is
//                 the end of frame marker with data zero
//   words before the start byte 0x02 are dropped, then come length, one header
//   word, the payload, two unchecked trailer words and the end marker
//   frames longer than BUFFER_DEPTH-5 yield nothing; BUFFER_DEPTH words from
//   their start byte are swallowed
//   path        : a word waits in the input stage until the result register is free,
//                 then its outcome, if any, is loaded there and raises res_valid
//   throughput  : one word per cycle while res_ready keeps the result register free,
//                 set by the phase and position update in the parser
//   reset       : rst_n low clears input stage, result register and parser
//                 state; the block comes out hunting for a start byte
//   stall       : with res_ready low the result word holds; one more word
//                 waits in the input stage, after which rx_ready drops
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stx_length_frame_deframer_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        rx_valid,
    output logic             rx_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             res_valid,
    input  wire logic        res_ready,
    output logic             kind,
    output logic [7:0]       data
);

    // input stage
    logic                  in_valid_reg, in_valid_next;
    logic [7:0]            in_byte_reg;
    logic                  slot_free;
    logic                  step;
    stx_dfr_pkg::result_t  res;

    // the input word moves on once the result register can take its outcome
    assign step     = in_valid_reg && slot_free;
    assign rx_ready = !in_valid_reg || step;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (rx_valid && rx_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // payload register, loaded on every accepted word
    always_ff @(posedge clk)
    begin
        if (rx_valid && rx_ready)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    // frame state machine, evaluates the held word
    stx_dfr_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_word (in_byte_reg),
        .res     (res)
    );

    // result register towards the receiver
    stx_dfr_outreg u_outreg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step),
        .res       (res),
        .slot_free (slot_free),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .kind      (kind),
        .data      (data)
    );

endmodule

`default_nettype wire

// ===== hdl/stx_dfr_checker.sv =====
// ----------------------------------------------------------------------------
// stx_dfr_props
// port-level checks of the deframer, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stx_dfr_props
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        rx_valid,
    input wire logic        rx_ready,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic        kind,
    input wire logic [7:0]  data
);

    // nothing to show while in reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !res_valid)
        else $error("result valid during reset");

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(kind) && $stable(data))
        else $error("result changed while stalled");

    // end marker carries zero data
    a_marker_data: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind |-> data == 8'd0)
        else $error("end marker with non-zero data");

    // a fresh result comes from an earlier accepted input word
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(rx_valid && rx_ready, 2))
        else $error("result without matching input word");

    // an empty result register never blocks the input
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> rx_ready)
        else $error("input stalled with empty result register");

endmodule

bind stx_length_frame_deframer_core stx_dfr_props u_stx_dfr_props
(
    .clk       (clk),
    .rst_n     (rst_n),
    .rx_valid  (rx_valid),
    .rx_ready  (rx_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .kind      (kind),
    .data      (data)
);

`default_nettype wire

// ===== test/stx_dfr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stx_dfr_checker
// watches both channels of the deframer, predicts the result words of every
// accepted received word and compares them in order with what comes out
// ----------------------------------------------------------------------------

module stx_dfr_checker
    import stx_dfr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       rx_valid,
    input  wire logic       rx_ready,
    input  wire logic [7:0] rx_byte,
    input  wire logic       res_valid,
    input  wire logic       res_ready,
    input  wire logic       kind,
    input  wire logic [7:0] data,
    output int              fails,
    output int              pending
);

    localparam int LEN_LIMIT  = BUFFER_DEPTH - 5;
    localparam int FIRST_DATA = 3;
    localparam int SKIP_LAST  = BUFFER_DEPTH - 1;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
    } out_word_t;

    out_word_t  expected_words[$];
    phase_t     parser_phase;
    logic [7:0] frame_pos;
    logic [7:0] hdr_len;
    int         fail_total;

    task automatic note_fail(input string what, input int want, input int got);
        $display("%0t: %s mismatch, expected %02h, actual %02h", $time, what, want, got);
        fail_total++;
    endtask

    // one received word through the frame parser, queueing any result word
    task automatic parse_word(input logic [7:0] b);
        int        idx;
        int        len;
        out_word_t w;
        idx = int'(frame_pos) + 1;
        len = int'(hdr_len);
        case (parser_phase)
            PH_LEN:
            begin
                frame_pos = 8'(idx);
                hdr_len = b;
                parser_phase = (int'(b) > LEN_LIMIT) ? PH_DISCARD : PH_BODY;
            end
            PH_BODY:
            begin
                frame_pos = 8'(idx);
                if (idx >= FIRST_DATA && idx < FIRST_DATA + len)
                begin
                    w.kind = KIND_PAYLOAD;
                    w.data = b;
                    expected_words.push_back(w);
                end
                else if (idx >= len + 4)
                begin
                    parser_phase = PH_HUNT;
                    frame_pos = 8'd0;
                    w.kind = KIND_END;
                    w.data = 8'd0;
                    expected_words.push_back(w);
                end
            end
            PH_DISCARD:
            begin
                frame_pos = 8'(idx);
                if (idx >= SKIP_LAST)
                begin
                    parser_phase = PH_HUNT;
                    frame_pos = 8'd0;
                end
            end
            default:
            begin
                frame_pos = 8'd0;
                parser_phase = (b == START_BYTE) ? PH_LEN : PH_HUNT;
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_word_t want;
        if (!rst_n)
        begin
            parser_phase = PH_HUNT;
            frame_pos = 8'd0;
            hdr_len = 8'd0;
            expected_words.delete();
            fail_total = 0;
            fails <= 0;
            pending <= 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    note_fail("unexpected word, kind", -1, int'(kind));
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (kind !== want.kind)
                        note_fail("kind", int'(want.kind), int'(kind));
                    if (data !== want.data)
                        note_fail("data", int'(want.data), int'(data));
                end
            end
            if (rx_valid && rx_ready)
                parse_word(rx_byte);
            fails <= fail_total;
            pending <= expected_words.size();
        end
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// random and directed byte streams into the stx deframer; a checker beside
// the block predicts payload and end-of-frame words and gives a failure count
// ----------------------------------------------------------------------------

module tb;

    import stx_dfr_pkg::*;

    // run length and pressure points; LIMIT, TAIL and HOLD_CYCLES count clock cycles, the rest received words
    localparam int LIMIT       = 500000;
    localparam int TAIL        = 20;
    localparam int ITEM_TARGET = 1450;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int FLOOD_END   = 700;
    localparam int PAUSE_AT    = 900;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       rx_valid;
    logic       rx_ready;
    logic [7:0] rx_byte;
    logic       res_valid;
    logic       res_ready;
    logic       kind;
    logic [7:0] data;

    int fails;
    int pending;
    int cycles = 0;
    int items_sent = 0;
    int quiet_left = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    stx_length_frame_deframer_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_ready  (rx_ready),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .kind      (kind),
        .data      (data)
    );

    stx_dfr_checker chk
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_ready  (rx_ready),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .kind      (kind),
        .data      (data),
        .fails     (fails),
        .pending   (pending)
    );

    // watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // idle stretch length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // offer one received word and hold it until taken, then maybe go idle;
    // valid is only lowered when a gap follows, so it never drops and rises
    // within the same step
    task automatic send_byte(input logic [7:0] b);
        int gap;
        rx_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (!rx_ready)
            @(posedge clk);
        items_sent++;
        if (items_sent >= HOLD_AT && items_sent < FLOOD_END)
        begin
            // flood while the sink holds off, so the block backs up
            gap = 0;
        end
        else if (quiet_left > 0)
        begin
            quiet_left--;
            gap = 0;
        end
        else
        begin
            gap = idle_len();
            if ($urandom_range(0, 99) < 3)
                quiet_left = $urandom_range(30, 100);
        end
        if (gap > 0)
        begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // well-formed frame with random header, payload and trailer; an oversized
    // length is followed by exactly enough words to fill the discard window
    task automatic send_frame(input int len);
        int body;
        send_byte(START_BYTE);
        send_byte(8'(len));
        send_byte(8'($urandom));
        if (len > BUFFER_DEPTH - 5)
            body = BUFFER_DEPTH - 3;
        else
            body = len + 2;
        repeat (body) send_byte(8'($urandom));
    endtask

    // result sink: random ready with one long hold-off once the flood begins
    initial
    begin : sink
        bit hold_done;
        int run;
        hold_done = 1'b0;
        res_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!hold_done && items_sent >= HOLD_AT)
            begin
                hold_done = 1'b1;
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if ($urandom_range(0, 99) < 60)
            begin
                res_ready <= 1'b1;
                if ($urandom_range(0, 19) == 0)
                    run = $urandom_range(50, 150);
                else
                    run = $urandom_range(1, 8);
                repeat (run) @(posedge clk);
            end
            else
            begin
                res_ready <= 1'b0;
                repeat (idle_len() + 1) @(posedge clk);
            end
        end
    end

    // word source and verdict
    initial
    begin : source
        logic [7:0] opening [22];
        bit         paused;
        int         pick;
        int         len;
        int         cut;
        paused = 1'b0;
        rst_n <= 1'b0;
        rx_valid <= 1'b0;
        rx_byte <= 8'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // line noise, zero length frame, one word frame, and a frame with
        // start bytes as header, payload and trailer
        opening = '{8'h00, 8'hFF, 8'h55, 8'hAA,
                    START_BYTE, 8'h00, 8'hFF, 8'h00, 8'hFF,
                    START_BYTE, 8'h01, 8'h00, 8'hFF, 8'h55, 8'hAA,
                    START_BYTE, 8'h02, START_BYTE, START_BYTE, 8'h00,
                    START_BYTE, START_BYTE};
        foreach (opening[i])
            send_byte(opening[i]);

        // largest length that fits, smallest that does not, and the top value
        send_frame(BUFFER_DEPTH - 5);
        send_frame(BUFFER_DEPTH - 4);
        send_frame(255);

        while (items_sent < ITEM_TARGET)
        begin
            if (!paused && items_sent >= PAUSE_AT)
            begin
                // sender quiet until every predicted word has been taken
                paused = 1'b1;
                rx_valid <= 1'b0;
                @(posedge clk);
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                send_frame($urandom_range(0, 12));
            end
            else if (pick < 73)
            begin
                send_frame($urandom_range(13, BUFFER_DEPTH - 5));
            end
            else if (pick < 76)
            begin
                send_frame($urandom_range(BUFFER_DEPTH - 4, 255));
            end
            else if (pick < 80)
            begin
                // frame cut short: the next start byte lands inside its body
                len = $urandom_range(1, 10);
                cut = $urandom_range(0, len + 1);
                send_byte(START_BYTE);
                send_byte(8'(len));
                repeat (cut) send_byte(8'($urandom));
            end
            else
            begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            end
        end

        rx_valid <= 1'b0;
        @(posedge clk);
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        // let any stray word out of the pipeline before judging
        repeat (TAIL) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
